// ===== src/rgb3k_pkg.sv =====
// Shared types and constants for the RGB 3x3 kernel filter.
package rgb3k_pkg;

	typedef enum logic [1:0] {
		K_EDGE    = 2'd0,
		K_SHARPEN = 2'd1,
		K_BOX     = 2'd2,
		K_GAUSS   = 2'd3
	} kern_t;

	typedef enum logic [2:0] {
		REG_KERNEL  = 3'd0,
		REG_WIDTH   = 3'd1,
		REG_HEIGHT  = 3'd2,
		REG_X_START = 3'd3,
		REG_Y_START = 3'd4,
		REG_X_END   = 3'd5,
		REG_Y_END   = 3'd6
	} cfg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 12;
	localparam int CNT_W      = 12;
	localparam int CMP_W      = 14;

	localparam logic [CNT_W-1:0] ROW_MAX = '1;

	// floor(x/9) == (x*BOX_RECIP) >> BOX_SHIFT for x < 32768
	localparam logic [12:0] BOX_RECIP = 13'd7282;
	localparam int          BOX_SHIFT = 16;

	typedef logic [23:0]     pix_t;
	typedef logic [8:0][7:0] chan9_t;

endpackage

// ===== src/rgb_3x3_kernel_filter.sv =====
// Top level of the RGB 3x3 kernel filter: line store, window, counters and output stage.
//
// Pixels enter in raster order on the in_* channel (valid/ready), one word per
// clock. Each accepted word reads and rewrites one column of the line store
// (two rows packed in one word) and shifts the 3x3 window. The result for the
// pixel centered in the window leaves on the out_* channel; the first result
// of a frame needs frame_width+2 words in, and frame_width+1 drain words after
// the last pixel flush the tail. frame_last marks the frame's last pixel.
// Throughput is one word per clock, set by the single read and single write
// port of the line store. An accepted word passes the memory read, window, group
// sum and combine registers, then the output register, before its result is on
// out_*. All stages advance together; while the output register holds a word
// that is not taken, the pipeline holds and in_ready is low.
// Configuration (cfg_*) is always ready. The user must write it only while no frame
// runs; the block does not enforce this. Reset clears the counters, the configuration
// and the stage valid bits; the line store and the window need no clearing, as every
// output reads only entries written earlier in the same frame.
module rgb_3x3_kernel_filter #(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [7:0]                       in_red,
	input  logic [7:0]                       in_green,
	input  logic [7:0]                       in_blue,
	input  logic                             is_drain,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_red,
	output logic [7:0]                       out_green,
	output logic [7:0]                       out_blue,
	output logic                             frame_last,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [rgb3k_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rgb3k_pkg::CFG_DATA_W-1:0] cfg_data
);
	import rgb3k_pkg::*;

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	// configuration
	kern_t            kernel_q;
	logic [11:0]      frame_width_q, frame_height_q;
	logic [10:0]      sel_x_start_q, sel_y_start_q;
	logic [11:0]      sel_x_end_q, sel_y_end_q;

	// counters
	logic [CNT_W-1:0] in_col_q, in_row_q, out_col_q, out_row_q;
	logic [CNT_W-1:0] in_col_d, in_row_d, out_col_d, out_row_d;

	logic             en, acc;
	logic [CMP_W-1:0] w_eff, h_eff;
	logic [CMP_W-1:0] in_col_p1, out_col_p1, out_row_p1;
	logic [31:0]      col32;
	logic [AW-1:0]    addr0;
	pix_t             px0;
	logic             primed0, filt0, last0, in_wrap;

	// stage 1: line store read data
	logic             v_s1, res_s1, filt_s1, last_s1, fwd_s1;
	pix_t             px_s1;
	logic [AW-1:0]    addr_s1;
	logic [47:0]      rd_s1, fwd_data_s1, lines;
	logic             wr_en;

	logic [47:0]      line_mem [MAX_WIDTH];
	pix_t             win_q [3][3];

	// later stages
	logic             v_s2, filt_s2, last_s2;
	logic             v_s3, filt_s3, last_s3;
	logic             v_s4, filt_s4, last_s4;
	pix_t             pass_s3, pass_s4;

	chan9_t           win_ch [3];
	logic [7:0]       chan_res [3];

	logic             out_valid_q, out_last_q;
	pix_t             out_pix_q;

	assign en        = !out_valid_q || out_ready;
	assign in_ready  = en;
	assign acc       = in_valid && en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_q       <= K_EDGE;
			frame_width_q  <= 12'd2048;
			frame_height_q <= 12'd2048;
			sel_x_start_q  <= '0;
			sel_y_start_q  <= '0;
			sel_x_end_q    <= 12'd2048;
			sel_y_end_q    <= 12'd2048;
		end else if (cfg_valid) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_KERNEL:  kernel_q       <= kern_t'(cfg_data[1:0]);
				REG_WIDTH:   frame_width_q  <= cfg_data;
				REG_HEIGHT:  frame_height_q <= cfg_data;
				REG_X_START: sel_x_start_q  <= cfg_data[10:0];
				REG_Y_START: sel_y_start_q  <= cfg_data[10:0];
				REG_X_END:   sel_x_end_q    <= cfg_data;
				REG_Y_END:   sel_y_end_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = CMP_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = CMP_W'(MAX_WIDTH);
		end else begin
			w_eff = CMP_W'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			h_eff = CMP_W'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			h_eff = CMP_W'(MAX_HEIGHT);
		end else begin
			h_eff = CMP_W'(frame_height_q);
		end
	end

	always_comb begin
		px0   = is_drain ? '0 : {in_blue, in_green, in_red};
		col32 = (32'(in_col_q) < MAX_WIDTH) ? 32'(in_col_q) : 32'(MAX_WIDTH - 1);
		addr0 = col32[AW-1:0];

		in_col_p1  = CMP_W'(in_col_q) + CMP_W'(1);
		out_col_p1 = CMP_W'(out_col_q) + CMP_W'(1);
		out_row_p1 = CMP_W'(out_row_q) + CMP_W'(1);

		primed0 = (in_row_q >= CNT_W'(2)) || (in_row_q == CNT_W'(1) && in_col_q != '0);
		filt0   = (out_row_q != '0) && (out_col_q != '0) &&
			(out_row_p1 < h_eff) && (out_col_p1 < w_eff) &&
			(out_row_q >= CNT_W'(sel_y_start_q)) && (out_row_q < sel_y_end_q) &&
			(out_col_q >= CNT_W'(sel_x_start_q)) && (out_col_q < sel_x_end_q);
		last0   = primed0 && (out_row_p1 >= h_eff) && (out_col_p1 >= w_eff);
		in_wrap = in_col_p1 >= w_eff;

		in_col_d  = in_wrap ? '0 : in_col_p1[CNT_W-1:0];
		in_row_d  = (in_wrap && in_row_q != ROW_MAX) ? in_row_q + CNT_W'(1) : in_row_q;
		out_col_d = out_col_q;
		out_row_d = out_row_q;
		if (last0) begin
			in_col_d  = '0;
			in_row_d  = '0;
			out_col_d = '0;
			out_row_d = '0;
		end else if (primed0) begin
			if (out_col_p1 >= w_eff) begin
				out_col_d = '0;
				if (out_row_q != ROW_MAX) begin
					out_row_d = out_row_q + CNT_W'(1);
				end
			end else begin
				out_col_d = out_col_p1[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (acc) begin
			in_col_q  <= in_col_d;
			in_row_q  <= in_row_d;
			out_col_q <= out_col_d;
			out_row_q <= out_row_d;
		end
	end

	// line store: word holds {row above, current row} at one column
	assign lines = fwd_s1 ? fwd_data_s1 : rd_s1;
	assign wr_en = en && v_s1;

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_s1 <= line_mem[addr0];
		end
		if (wr_en) begin
			line_mem[addr_s1] <= {lines[23:0], px_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (en) begin
			v_s1   <= acc;
			fwd_s1 <= acc && v_s1 && (addr_s1 == addr0);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1       <= px0;
			addr_s1     <= addr0;
			res_s1      <= primed0;
			filt_s1     <= filt0;
			last_s1     <= last0;
			fwd_data_s1 <= {lines[23:0], px_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int r = 0; r < 3; r++) begin
				win_q[r][0] <= win_q[r][1];
				win_q[r][1] <= win_q[r][2];
			end
			win_q[0][2] <= lines[47:24];
			win_q[1][2] <= lines[23:0];
			win_q[2][2] <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && res_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			filt_s2 <= filt_s1;
			last_s2 <= last_s1;
			filt_s3 <= filt_s2;
			last_s3 <= last_s2;
			pass_s3 <= win_q[1][1];
			filt_s4 <= filt_s3;
			last_s4 <= last_s3;
			pass_s4 <= pass_s3;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_ch[k][r*3+c] = win_q[r][c][8*k +: 8];
				end
			end
		end
	end

	for (genvar k = 0; k < 3; k++) begin : g_chan
		rgb3k_chan u_chan (
			.clk  (clk),
			.en   (en),
			.kern (kernel_q),
			.win  (win_ch[k]),
			.res  (chan_res[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_pix_q  <= filt_s4 ? {chan_res[2], chan_res[1], chan_res[0]} : pass_s4;
			out_last_q <= last_s4;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_pix_q[7:0];
	assign out_green  = out_pix_q[15:8];
	assign out_blue   = out_pix_q[23:16];
	assign frame_last = out_last_q;

`ifndef SYNTH
	a_fwd_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("line store bypass flagged without an item in stage 1");

	a_out_from_s4: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_s4))
		else $error("output word appeared without a stage 4 result");

	a_frame_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		acc && last0 |=> in_col_q == '0 && in_row_q == '0 &&
			out_col_q == '0 && out_row_q == '0)
		else $error("counters not cleared after frame end");

	a_write_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> $past(v_s1 || acc))
		else $error("line store written without a prior read");
`endif

endmodule

// ===== src/rgb3k_chan.sv =====
// One color channel of the 3x3 kernel arithmetic: group sums, kernel combine, scale and clamp.
module rgb3k_chan (
	input  logic             clk,
	input  logic             en,
	input  rgb3k_pkg::kern_t kern,
	input  rgb3k_pkg::chan9_t win,
	output logic [7:0]       res
);
	import rgb3k_pkg::*;

	logic [7:0]         ctr_s3;
	logic [9:0]         side_s3;
	logic [9:0]         corner_s3;
	logic signed [13:0] c_x, sd_x, cr_x, comb;
	logic signed [12:0] sum_s4;
	logic [12:0]        sum_u;
	logic [11:0]        box_in;
	logic [24:0]        box_prod;
	logic [12:0]        gauss_q;
	logic signed [13:0] scaled;

	always_ff @(posedge clk) begin
		if (en) begin
			ctr_s3    <= win[4];
			side_s3   <= 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
			corner_s3 <= 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
		end
	end

	always_comb begin
		c_x  = signed'({6'd0, ctr_s3});
		sd_x = signed'({4'd0, side_s3});
		cr_x = signed'({4'd0, corner_s3});
		unique case (kern)
			K_EDGE:    comb = (c_x <<< 3) - sd_x - cr_x;
			K_SHARPEN: comb = (c_x <<< 2) + c_x - sd_x;
			K_BOX:     comb = c_x + sd_x + cr_x;
			K_GAUSS:   comb = (c_x <<< 2) + (sd_x <<< 1) + cr_x;
			default:   comb = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s4 <= 13'(comb);
		end
	end

	always_comb begin
		sum_u    = unsigned'(sum_s4);
		box_in   = 12'(sum_u + 13'd4);
		box_prod = 25'(box_in) * 25'(BOX_RECIP);
		gauss_q  = (sum_u + 13'd8) >> 4;
		unique case (kern)
			K_BOX:   scaled = signed'(14'(box_prod[24:BOX_SHIFT]));
			K_GAUSS: scaled = signed'({1'b0, gauss_q});
			default: scaled = 14'(sum_s4);
		endcase
		if (scaled < 14'sd0) begin
			res = 8'd0;
		end else if (scaled > 14'sd255) begin
			res = 8'd255;
		end else begin
			res = scaled[7:0];
		end
	end

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the RGB 3x3 kernel filter with a line-accurate predictor.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import rgb3k_pkg::*;

	localparam int MAX_W = 2048;
	localparam int MAX_H = 2048;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 3'd7;
	localparam int PIX_UNIFORM = 0;
	localparam int PIX_EXTREME = 1;
	localparam int PIX_SMOOTH  = 2;
	localparam int RANDOM_WORDS = 990;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_end;
	} rgb_out_t;

	class rgb_window_calc #(int MW = 2048, int MH = 2048);
		pix_t line_mem[2*MW];
		pix_t win[3][3];
		int unsigned in_col, in_row, out_col, out_row;
		kern_t kern;
		logic [11:0] width, height, x_end, y_end;
		logic [10:0] x_start, y_start;
		rgb_out_t pending_pixels[$];
		int bad_fields;

		function new();
			int i;
			for (i = 0; i < 2*MW; i++)
				line_mem[i] = '0;
			for (i = 0; i < 9; i++)
				win[i/3][i%3] = '0;
			in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			kern = K_EDGE;
			width = 12'd2048; height = 12'd2048;
			x_start = '0; y_start = '0;
			x_end = 12'd2048; y_end = 12'd2048;
			bad_fields = 0;
		endfunction

		function int unsigned eff_size(logic [11:0] v, int unsigned maxv);
			if (v == 0)
				return 1;
			return (v > maxv) ? maxv : v;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_KERNEL:  kern = kern_t'(data[1:0]);
				REG_WIDTH:   width = data;
				REG_HEIGHT:  height = data;
				REG_X_START: x_start = data[10:0];
				REG_Y_START: y_start = data[10:0];
				REG_X_END:   x_end = data;
				REG_Y_END:   y_end = data;
				default: ;
			endcase
		endfunction

		function int weight(int r, int c);
			case (kern)
				K_EDGE:    return (r == 1 && c == 1) ? 8 : -1;
				K_SHARPEN: return (r == 1 && c == 1) ? 5 : ((r == 1 || c == 1) ? -1 : 0);
				K_BOX:     return 1;
				default:   return (r == 1 ? 2 : 1) * (c == 1 ? 2 : 1);
			endcase
		endfunction

		function logic [7:0] filter_chan(int sh);
			int s, r, c;
			s = 0;
			for (r = 0; r < 3; r++)
				for (c = 0; c < 3; c++)
					s += weight(r, c) * int'(win[r][c][sh +: 8]);
			if (kern == K_BOX)
				s = (s + 4) / 9;
			else if (kern == K_GAUSS)
				s = (s + 8) / 16;
			if (s < 0)
				s = 0;
			if (s > 255)
				s = 255;
			return s[7:0];
		endfunction

		function void take_pixel(logic [7:0] red, green, blue, logic drain);
			int unsigned w, h, col;
			int rr;
			pix_t px, top, mid;
			bit primed, filt;
			rgb_out_t o;
			w = eff_size(width, MW);
			h = eff_size(height, MH);
			px = drain ? '0 : {blue, green, red};
			col = (in_col < MW) ? in_col : MW - 1;
			top = line_mem[MW + col];
			mid = line_mem[col];
			for (rr = 0; rr < 3; rr++) begin
				win[rr][0] = win[rr][1];
				win[rr][1] = win[rr][2];
			end
			win[0][2] = top;
			win[1][2] = mid;
			win[2][2] = px;
			line_mem[MW + col] = mid;
			line_mem[col] = px;
			primed = in_row >= 2 || (in_row == 1 && in_col >= 1);
			if (in_col + 1 >= w) begin
				in_col = 0;
				if (in_row < 4095)
					in_row++;
			end else begin
				in_col++;
			end
			if (!primed)
				return;
			filt = out_row > 0 && out_col > 0 && out_row + 1 < h && out_col + 1 < w &&
				out_row >= y_start && out_row < y_end &&
				out_col >= x_start && out_col < x_end;
			if (filt) begin
				o.red = filter_chan(0);
				o.green = filter_chan(8);
				o.blue = filter_chan(16);
			end else begin
				o.red = win[1][1][7:0];
				o.green = win[1][1][15:8];
				o.blue = win[1][1][23:16];
			end
			o.frame_end = (out_row + 1 >= h) && (out_col + 1 >= w);
			pending_pixels.push_back(o);
			if (o.frame_end) begin
				in_col = 0; in_row = 0; out_col = 0; out_row = 0;
			end else if (out_col + 1 >= w) begin
				out_col = 0;
				if (out_row < 4095)
					out_row++;
			end else begin
				out_col++;
			end
		endfunction

		function void compare(string name, logic [7:0] e, logic [7:0] a);
			if (a !== e) begin
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
				bad_fields++;
			end
		endfunction

		function void check_pixel(logic [7:0] red, green, blue, logic fl);
			rgb_out_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected output word r=%0d g=%0d b=%0d last=%0d",
					$time, red, green, blue, fl);
				bad_fields++;
				return;
			end
			e = pending_pixels.pop_front();
			compare("out_red", e.red, red);
			compare("out_green", e.green, green);
			compare("out_blue", e.blue, blue);
			compare("frame_last", 8'(e.frame_end), 8'(fl));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_red = '0;
	logic [7:0] in_green = '0;
	logic [7:0] in_blue = '0;
	logic is_drain = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [7:0] out_red, out_green, out_blue;
	logic frame_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	rgb_window_calc #(MAX_W, MAX_H) sb;
	bit src_quiet = 1'b0;
	bit sink_quiet = 1'b0;
	int sink_hold = 0;
	int quiet_timer = 0;
	int word_count = 0;

	rgb_3x3_kernel_filter #(
		.MAX_WIDTH(MAX_W),
		.MAX_HEIGHT(MAX_H)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_red(in_red),
		.in_green(in_green),
		.in_blue(in_blue),
		.is_drain(is_drain),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_red(out_red),
		.out_green(out_green),
		.out_blue(out_blue),
		.frame_last(frame_last),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 90)
			return $urandom_range(1, 3);
		if (p < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] pick_chan(int style, int base);
		int v;
		case (style)
			PIX_UNIFORM: return 8'($urandom_range(0, 255));
			PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: begin
				v = base + int'($urandom_range(0, 6)) - 3;
				if (v < 0)
					v = 0;
				if (v > 255)
					v = 255;
				return v[7:0];
			end
		endcase
	endfunction

	// sink stalls
	always @(negedge clk) begin
		if (sink_hold != 0) begin
			out_ready <= 1'b0;
			sink_hold <= sink_hold - 1;
		end else begin
			out_ready <= 1'b1;
			sink_hold <= sink_quiet ? 0 : pick_gap();
		end
	end

	always @(negedge clk) begin
		if (quiet_timer == 0) begin
			sink_quiet <= ($urandom_range(0, 3) == 0);
			quiet_timer <= $urandom_range(50, 400);
		end else begin
			quiet_timer <= quiet_timer - 1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_pixel(out_red, out_green, out_blue, frame_last);
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_reg(idx, data);
		@(negedge clk);
	endtask

	task automatic apply_setup(kern_t k, logic [11:0] w, h, xs, ys, xe, ye);
		logic [9:0] junk;
		junk = 10'($urandom);
		write_reg(REG_KERNEL, {junk, k});
		write_reg(REG_WIDTH, w);
		write_reg(REG_HEIGHT, h);
		write_reg(REG_X_START, xs);
		write_reg(REG_Y_START, ys);
		write_reg(REG_X_END, xe);
		write_reg(REG_Y_END, ye);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_word(logic [7:0] red, green, blue, logic drain);
		int gap;
		gap = src_quiet ? 0 : pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_red <= red;
		in_green <= green;
		in_blue <= blue;
		is_drain <= drain;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.take_pixel(red, green, blue, drain);
		word_count++;
		@(negedge clk);
	endtask

	task automatic hold_until_empty();
		in_valid <= 1'b0;
		while (sb.pending_pixels.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic settle();
		hold_until_empty();
		repeat (8) @(negedge clk);
	endtask

	// one frame of w*h pixels plus w+1 drain words
	task automatic run_frame(int w, int h, int pause_at);
		int n, total, style, base, noise;
		bit drain;
		total = w * h + w + 1;
		style = $urandom_range(PIX_UNIFORM, PIX_SMOOTH);
		base = $urandom_range(0, 255);
		noise = ($urandom_range(0, 4) == 0) ? $urandom_range(2, 10) : 0;
		src_quiet = ($urandom_range(0, 3) == 0);
		for (n = 0; n < total; n++) begin
			if (n == pause_at)
				hold_until_empty();
			drain = (n >= w * h);
			if ($urandom_range(0, 99) < noise)
				drain = !drain;
			send_word(pick_chan(style, base), pick_chan(style, base),
				pick_chan(style, base), drain);
		end
	endtask

	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin : stimulus
		int n, phase, w, h, frames, f, mode, start_count;
		int unsigned xs, xe, ys, ye;
		logic [11:0] wv, hv;
		kern_t k;
		sb = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_reg(REG_NONE, 12'($urandom));
		apply_setup(K_EDGE, 12'd3, 12'd3, 12'd0, 12'd0, 12'd3, 12'd3);
		// center drives both clamps; a drain inside the frame, a pixel in a drain slot
		for (n = 0; n < 13; n++) begin
			if (n == 4)
				send_word(8'hFF, 8'h00, 8'hC8, 1'b0);
			else
				send_word(8'h00, 8'hFF, 8'h19, (n >= 9 && n != 10) || n == 8);
		end
		settle();
		apply_setup(K_BOX, 12'd3, 12'd3, 12'd0, 12'd0, 12'd3, 12'd3);
		for (n = 0; n < 13; n++)
			send_word(8'hFF, 8'hFF, 8'hFF, n >= 9);
		settle();

		phase = 0;
		start_count = word_count;
		while (word_count - start_count < RANDOM_WORDS) begin
			n = $urandom_range(0, 99);
			w = (n < 70) ? $urandom_range(1, 8) : (n < 95) ? $urandom_range(9, 24) :
				$urandom_range(25, 64);
			h = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 16) : $urandom_range(1, 8);
			k = (phase < 4) ? kern_t'(phase % 4) : kern_t'($urandom_range(0, 3));
			mode = $urandom_range(0, 8);
			if (mode <= 5) begin
				xs = $urandom_range(0, w - 1);
				xe = $urandom_range(xs + 1, w);
				ys = $urandom_range(0, h - 1);
				ye = $urandom_range(ys + 1, h);
			end else if (mode == 6) begin
				xs = 0; ys = 0; xe = 12'hFFF; ye = 12'hFFF;
			end else if (mode == 7) begin
				xs = $urandom_range(0, w);
				xe = $urandom_range(0, xs);
				ys = $urandom_range(0, h);
				ye = $urandom_range(0, h);
			end else begin
				xs = $urandom & 12'hFFF;
				xe = $urandom & 12'hFFF;
				ys = $urandom & 12'hFFF;
				ye = $urandom & 12'hFFF;
			end
			wv = (w == 1 && $urandom_range(0, 1)) ? 12'd0 : 12'(w);
			hv = (h == 1 && $urandom_range(0, 1)) ? 12'd0 : 12'(h);
			if ($urandom_range(0, 5) == 0)
				write_reg(REG_NONE, 12'($urandom));
			apply_setup(k, wv, hv, 12'(xs), 12'(ys), 12'(xe), 12'(ye));
			frames = $urandom_range(1, 3);
			for (f = 0; f < frames; f++)
				run_frame(w, h, (phase == 2 && f == 0) ? (w * h + w + 1) / 2 : -1);
			settle();
			phase++;
		end

		repeat (20) @(posedge clk);
		if (sb.bad_fields == 0 && sb.pending_pixels.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (sb.pending_pixels.size() != 0)
				$display("%0t: %0d expected words never arrived", $time,
					sb.pending_pixels.size());
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/rgb3k_pkg.sv
src/rgb3k_chan.sv
src/rgb_3x3_kernel_filter.sv
tb/sv/testbench.sv
